// ----- design/mvpm_pkg.sv -----
// mvpm_pkg: shared codes, item types and fixed constants of the pcm mixer
// used by every module of the multi voice pcm mixer; no dependencies
`timescale 1ns / 1ps

package mvpm_pkg;

    localparam int ADDR_W = 16;
    localparam int SMP_W  = 16;
    localparam int LEN_W  = 17;
    localparam int VOL_W  = 7;

    // operation codes on the input tuser
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_QUEUE  = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [VOL_W-1:0] VOL_MAX = 7'd100;

    // x / 100 as (x * DIV_M) >> DIV_SHIFT, exact for x below 2^22
    localparam logic [22:0] DIV_M     = 23'd5368710;
    localparam int          DIV_SHIFT = 29;

    // reciprocal shift used for the address reduction
    localparam int MOD_SHIFT = 24;

    // free slot search width per cycle
    localparam int CHUNK = 8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QAW         = 2;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_LOAD,
        KIND_QUEUE,
        KIND_TICK
    } kind_t;

    typedef struct packed {
        kind_t                    kind;
        logic [ADDR_W-1:0]        addr;
        logic signed [SMP_W-1:0]  smp;
        logic [LEN_W-1:0]         len;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD_MUL,
        ST_MOD_SUB,
        ST_MOD_FIX,
        ST_SEARCH,
        ST_TICK,
        ST_DONE
    } state_t;

endpackage

// ----- design/mvpm_front.sv -----
// mvpm_front: input acceptance, operation decode and the item queue
// depends on mvpm_pkg
`timescale 1ns / 1ps

module mvpm_front
    import mvpm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // address, sample_value, sound_length, zero fill
    input  logic [1:0]  s_tuser,   // operation
    output logic        q_valid,
    input  logic        q_ready,
    output item_t       q_entry
);

    item_t              queue_mem [QUEUE_DEPTH];
    logic [QAW:0]       wr_ptr_reg;
    logic [QAW:0]       rd_ptr_reg;
    logic               full;
    logic               empty;
    item_t              in_item;

    assign full  = (wr_ptr_reg[QAW] != rd_ptr_reg[QAW]) &&
                   (wr_ptr_reg[QAW-1:0] == rd_ptr_reg[QAW-1:0]);
    assign empty = (wr_ptr_reg == rd_ptr_reg);

    assign s_tready = !full;
    assign q_valid  = !empty;
    assign q_entry  = queue_mem[rd_ptr_reg[QAW-1:0]];

    always_comb
    begin
        in_item.addr = s_tdata[15:0];
        in_item.smp  = s_tdata[31:16];
        in_item.len  = s_tdata[48:32];
        unique case (s_tuser)
            OP_LOAD:   in_item.kind = KIND_LOAD;
            OP_QUEUE:  in_item.kind = KIND_QUEUE;
            OP_TICK:   in_item.kind = KIND_TICK;
            OP_UNUSED: in_item.kind = KIND_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            if (s_tvalid && !full)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (q_ready && !empty)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && !full)
            queue_mem[wr_ptr_reg[QAW-1:0]] <= in_item;
    end

endmodule

// ----- design/mvpm_back.sv -----
// mvpm_back: executes queued items: sample loads, voice allocation and the mix walk
// holds the sample memory, voice slot table, volume register and result register
// depends on mvpm_pkg
`timescale 1ns / 1ps

module mvpm_back
    import mvpm_pkg::*;
#(
    parameter int VOICES       = 30,
    parameter int SAMPLE_WORDS = 65536
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_ready,
    input  item_t             q_entry,
    input  logic              cfg_we,
    input  logic [VOL_W-1:0]  cfg_wdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,
    output logic [0:0]        m_tuser
);

    localparam int AW     = $clog2(SAMPLE_WORDS);
    localparam int VW     = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int NCHUNK = (VOICES + CHUNK - 1) / CHUNK;
    localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int SLOT_W = AW + 2 * LEN_W;
    localparam int MOD_M  = (1 << MOD_SHIFT) / SAMPLE_WORDS;

    state_t                  state_reg, state_next;
    item_t                   cur_reg;
    logic [VOL_W-1:0]        vol_reg;
    logic [VOICES-1:0]       slot_active_reg;
    logic                    res_status_reg;

    logic signed [SMP_W-1:0] sample_mem [SAMPLE_WORDS];
    logic [SLOT_W-1:0]       slot_mem [VOICES];

    // address reduction
    logic [32:0]             mod_prod;
    logic [8:0]              q_est_reg;
    logic [29:0]             mod_back;
    logic [29:0]             mod_sub;
    logic [AW:0]             r_reg;
    logic [AW:0]             r_fix;
    logic [AW-1:0]           red_addr;
    logic [AW-1:0]           red_reg;

    // free slot search
    logic [CW-1:0]           chunk_reg;
    logic [NCHUNK*CHUNK-1:0] act_pad;
    logic [CHUNK-1:0]        chunk_bits;
    logic                    found;
    logic [2:0]              found_bit;
    logic [VW-1:0]           found_idx;
    logic                    last_chunk;

    // mix walk
    logic [VW-1:0]           iss_reg;
    logic                    iss_done_reg;
    logic                    v1_reg, v2_reg, v3_reg, v4_reg;
    logic                    act1_reg;
    logic [VW-1:0]           idx1_reg;
    logic [SLOT_W-1:0]       slot_rd_reg;
    logic [AW-1:0]           s1_addr;
    logic [LEN_W-1:0]        s1_pos;
    logic [LEN_W-1:0]        s1_len;
    logic                    play1;
    logic                    free1;
    logic [LEN_W-1:0]        pos_inc;
    logic [AW-1:0]           addr_inc;
    logic signed [SMP_W-1:0] smp_rd_reg;
    logic [SMP_W-1:0]        mag2;
    logic [22:0]             prod_reg;
    logic                    neg3_reg, neg4_reg;
    logic [45:0]             div_prod;
    logic [15:0]             quo_reg;
    logic signed [16:0]      scaled;
    logic signed [17:0]      sum_ext;
    logic signed [15:0]      sum_clip;
    logic signed [15:0]      sum_reg;
    logic                    tick_end;

    // slot table write port
    logic                    sm_we;
    logic [VW-1:0]           sm_waddr;
    logic [SLOT_W-1:0]       sm_wdata;

    // result register
    logic                    out_valid_reg;
    logic [15:0]             out_sample_reg;
    logic                    out_status_reg;
    logic                    out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sample_reg;
    assign m_tuser  = out_status_reg;

    // address modulo memory depth
    assign mod_prod = 33'(cur_reg.addr) * 33'(MOD_M);
    assign mod_back = 30'(q_est_reg) * 30'(SAMPLE_WORDS);
    assign mod_sub  = 30'(cur_reg.addr) - mod_back;
    assign r_fix    = (r_reg >= (AW+1)'(SAMPLE_WORDS)) ? r_reg - (AW+1)'(SAMPLE_WORDS) : r_reg;
    assign red_addr = r_fix[AW-1:0];

    // lowest free slot, one chunk per cycle
    always_comb
    begin
        act_pad = '1;
        act_pad[VOICES-1:0] = slot_active_reg;
        chunk_bits = act_pad[chunk_reg*CHUNK +: CHUNK];
        found = 1'b0;
        found_bit = '0;
        for (int b = CHUNK - 1; b >= 0; b--)
        begin
            if (!chunk_bits[b])
            begin
                found = 1'b1;
                found_bit = 3'(b);
            end
        end
    end

    assign found_idx  = VW'({chunk_reg, found_bit});
    assign last_chunk = (chunk_reg == CW'(NCHUNK - 1));

    // walk stage 1: slot entry read back
    assign s1_addr  = slot_rd_reg[SLOT_W-1:2*LEN_W];
    assign s1_pos   = slot_rd_reg[2*LEN_W-1:LEN_W];
    assign s1_len   = slot_rd_reg[LEN_W-1:0];
    assign play1    = act1_reg && (s1_pos < s1_len);
    assign pos_inc  = s1_pos + 1'b1;
    assign addr_inc = (s1_addr == AW'(SAMPLE_WORDS - 1)) ? '0 : s1_addr + 1'b1;
    assign free1    = act1_reg && (!play1 || (pos_inc >= s1_len));

    // walk stage 2 and 3: magnitude times volume, then divide by 100
    assign mag2     = smp_rd_reg[SMP_W-1] ? 16'(-smp_rd_reg) : 16'(smp_rd_reg);
    assign div_prod = 46'(prod_reg) * 46'(DIV_M);

    // walk stage 4: signed add with clipping
    assign scaled   = neg4_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign sum_ext  = {{2{sum_reg[15]}}, sum_reg} + {scaled[16], scaled};

    always_comb
    begin
        if (sum_ext > 18'sd32767)
            sum_clip = 16'sh7fff;
        else if (sum_ext < -18'sd32768)
            sum_clip = -16'sh8000;
        else
            sum_clip = sum_ext[15:0];
    end

    assign tick_end = iss_done_reg && !v1_reg && !v2_reg && !v3_reg && !v4_reg;

    always_comb
    begin
        sm_we    = 1'b0;
        sm_waddr = idx1_reg;
        sm_wdata = {addr_inc, pos_inc, s1_len};
        if (state_reg == ST_SEARCH)
        begin
            sm_we    = found;
            sm_waddr = found_idx;
            sm_wdata = {red_reg, {LEN_W{1'b0}}, cur_reg.len};
        end
        else if (v1_reg && play1)
        begin
            sm_we = 1'b1;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        q_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                q_ready = 1'b1;
                if (q_valid)
                begin
                    unique case (q_entry.kind)
                        KIND_LOAD:  state_next = ST_MOD_MUL;
                        KIND_QUEUE: state_next = ST_MOD_MUL;
                        KIND_TICK:  state_next = ST_TICK;
                        KIND_NONE:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_MOD_MUL: state_next = ST_MOD_SUB;
            ST_MOD_SUB: state_next = ST_MOD_FIX;
            ST_MOD_FIX: state_next = (cur_reg.kind == KIND_LOAD) ? ST_DONE : ST_SEARCH;
            ST_SEARCH:
            begin
                if (found || last_chunk)
                    state_next = ST_DONE;
            end
            ST_TICK:
            begin
                if (tick_end)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vol_reg         <= '0;
            slot_active_reg <= '0;
            out_valid_reg   <= 1'b0;
            iss_done_reg    <= 1'b0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            v3_reg          <= 1'b0;
            v4_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_wdata <= VOL_MAX))
                vol_reg <= cfg_wdata;

            if (state_reg == ST_SEARCH && found)
                slot_active_reg[found_idx] <= 1'b1;
            if (v1_reg && free1)
                slot_active_reg[idx1_reg] <= 1'b0;

            if (state_reg == ST_IDLE)
                iss_done_reg <= 1'b0;
            else if (state_reg == ST_TICK && !iss_done_reg && iss_reg == VW'(VOICES - 1))
                iss_done_reg <= 1'b1;

            v1_reg <= (state_reg == ST_TICK) && !iss_done_reg;
            v2_reg <= v1_reg && play1;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;

            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid)
        begin
            cur_reg        <= q_entry;
            sum_reg        <= '0;
            res_status_reg <= 1'b0;
        end

        if (state_reg == ST_IDLE)
            iss_reg <= '0;
        else if (state_reg == ST_TICK && !iss_done_reg && iss_reg != VW'(VOICES - 1))
            iss_reg <= iss_reg + 1'b1;

        q_est_reg <= mod_prod[MOD_SHIFT+8:MOD_SHIFT];
        r_reg     <= mod_sub[AW:0];

        if (state_reg == ST_MOD_FIX)
        begin
            red_reg   <= red_addr;
            chunk_reg <= '0;
        end
        else if (state_reg == ST_SEARCH)
        begin
            if (!found && last_chunk)
                res_status_reg <= 1'b1;
            else if (!found)
                chunk_reg <= chunk_reg + 1'b1;
        end

        act1_reg <= slot_active_reg[iss_reg];
        idx1_reg <= iss_reg;
        prod_reg <= 23'(mag2) * 23'(vol_reg);
        neg3_reg <= smp_rd_reg[SMP_W-1];
        quo_reg  <= div_prod[DIV_SHIFT+15:DIV_SHIFT];
        neg4_reg <= neg3_reg;

        if (v4_reg)
            sum_reg <= sum_clip;

        if (state_reg == ST_DONE && out_free)
        begin
            out_sample_reg <= (cur_reg.kind == KIND_TICK) ? sum_reg : '0;
            out_status_reg <= res_status_reg;
        end
    end

    // sample memory
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_MOD_FIX && cur_reg.kind == KIND_LOAD)
            sample_mem[red_addr] <= cur_reg.smp;
        if (v1_reg && play1)
            smp_rd_reg <= sample_mem[s1_addr];
    end

    // voice slot table: current address, position, length
    always_ff @(posedge clk)
    begin
        if (sm_we)
            slot_mem[sm_waddr] <= sm_wdata;
        slot_rd_reg <= slot_mem[iss_reg];
    end

endmodule

// ----- design/multi_voice_pcm_mixer_unit.sv -----
// multi_voice_pcm_mixer_unit: top level of the multi voice pcm mixer
// instantiates mvpm_front and mvpm_back; depends on mvpm_pkg
//
//   channel   direction  handshake            payload
//   s_*       in         s_tvalid / s_tready  tdata: address, sample_value, sound_length
//                                             tuser: operation
//   m_*       out        m_tvalid / m_tready  tdata: mixed_sample; tuser: status
//   cfg_*     in         cfg_we               cfg_wdata: volume_percent
//
// load runs the address reduction; queue adds the free slot search in 8-slot chunks,
// tick walks the slot table through its one read port
// and the four-stage mix pipeline behind it
// a 4-entry item queue takes input while the back end works or its result waits
// reset clears control, slot valid bits and volume; the sample memory is not cleared
`timescale 1ns / 1ps

module multi_voice_pcm_mixer_unit
    import mvpm_pkg::*;
#(
    parameter int VOICES       = 30,
    parameter int SAMPLE_WORDS = 65536
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // address, sample_value, sound_length, zero fill
    input  logic [1:0]  s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // mixed_sample
    output logic [0:0]  m_tuser,   // status
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata
);

    logic  q_valid;
    logic  q_ready;
    item_t q_entry;

    mvpm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_entry  (q_entry)
    );

    mvpm_back #(
        .VOICES       (VOICES),
        .SAMPLE_WORDS (SAMPLE_WORDS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_entry   (q_entry),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ----- design/mvpm_checker.sv -----
// mvpm_checker: port level checks of the pcm mixer, bound to the top level
// depends on mvpm_pkg and multi_voice_pcm_mixer_unit
`timescale 1ns / 1ps

module mvpm_checker
    import mvpm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic [0:0]  m_tuser
);

    logic [3:0] pending_reg;

    // items accepted whose result is not yet taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_reg + 4'((s_tvalid && s_tready) ? 1 : 0)
                                       - 4'((m_tvalid && m_tready) ? 1 : 0);
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == 16'd0)
        else $error("dropped queue item carries a nonzero sample");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> pending_reg != 4'd0)
        else $error("result without an accepted item");

    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 4'(QUEUE_DEPTH + 2))
        else $error("more items in flight than the block can hold");

endmodule

bind multi_voice_pcm_mixer_unit mvpm_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
